@@ hdl/sle_pkg.sv @@
// Shared types, character codes and helpers for the serial line editor.
// No dependencies; every other file but sle_if imports this package.
`default_nettype none

package sle_pkg;

	localparam int LINE_DEPTH_DEF = 32;
	localparam int FIFO_DEPTH     = 4;
	localparam int LEN_W          = 6;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// Edit commands handed from the front to the back.
	typedef enum logic [1:0] {
		OP_PUT,
		OP_DEL,
		OP_CR
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

	function automatic logic hex_or_space(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46) || (c == CH_SPACE);
	endfunction

endpackage

`default_nettype wire

@@ hdl/sle_if.sv @@
// Valid/ready channel interfaces for received bytes and echo words.
// No dependencies.
`default_nettype none

interface sle_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sle_echo_if;
	logic       valid;
	logic       ready;
	logic [7:0] echo_byte;
	logic       last_of_run;
	logic       line_done;
	logic       line_well_formed;
	logic [5:0] line_length;

	modport source (output valid, output echo_byte, output last_of_run, output line_done,
		output line_well_formed, output line_length, input ready);
	modport sink (input valid, input echo_byte, input last_of_run, input line_done,
		input line_well_formed, input line_length, output ready);
endinterface

`default_nettype wire

@@ hdl/sle_front.sv @@
// Input side: escape skipping and byte classification into edit commands.
// Depends on sle_pkg and sle_rx_if.
`default_nettype none

module sle_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	sle_rx_if.sink             rx,
	output sle_pkg::cmd_t      cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_ready
);
	import sle_pkg::*;

	logic [1:0] skip_q;
	logic       take;
	logic       is_cmd;

	assign rx.ready = cmd_ready;
	assign take     = rx.valid && rx.ready;

	always_comb begin
		is_cmd   = 1'b0;
		cmd.op   = OP_PUT;
		cmd.data = rx.rx_byte;
		if (rx.rx_byte == CH_DEL) begin
			is_cmd = 1'b1;
			cmd.op = OP_DEL;
		end else if (rx.rx_byte == CH_CR) begin
			is_cmd = 1'b1;
			cmd.op = OP_CR;
		end else if (rx.rx_byte >= CH_SPACE && rx.rx_byte <= CH_TILDE) begin
			is_cmd = 1'b1;
		end
	end

	// Pushes only while no escape bytes are pending.
	assign cmd_valid = rx.valid && (skip_q == 2'd0) && is_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 2'd0;
		end else if (take) begin
			if (skip_q != 2'd0) begin
				skip_q <= skip_q - 2'd1;
			end else if (rx.rx_byte == CH_ESC) begin
				skip_q <= 2'd2;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/sle_fifo.sv @@
// Short command queue between front and back.
// Depends on sle_pkg.
`default_nettype none

module sle_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sle_pkg::cmd_t push_cmd,
	input  wire logic          push_valid,
	output logic               push_ready,
	output sle_pkg::cmd_t      pop_cmd,
	output logic               pop_valid,
	input  wire logic          pop_ready
);
	import sle_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	cmd_t          entry_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != (PW+1)'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/sle_back.sv @@
// Execution side: line store, fill count, end-of-line format scan, echo register.
// Depends on sle_pkg and sle_echo_if.
`default_nettype none

module sle_back #(
	parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sle_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	sle_echo_if.source         echo
);
	import sle_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEL_SP,
		ST_DEL_BS,
		ST_SCAN,
		ST_CR,
		ST_LF
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  fill_q;
	logic [CW-1:0]  scan_idx_q;
	logic           bad_q;
	logic           sp2_q;
	logic           sp3_q;
	logic           rd_v_s1;
	logic [CW-1:0]  rd_pos_s1;
	logic [7:0]     rdata_s1;
	logic [7:0]     store [LINE_DEPTH];

	logic           out_valid_q;
	logic [7:0]     echo_byte_q;
	logic           last_q;
	logic           done_q;
	logic           well_q;
	logic [LEN_W-1:0] len_q;

	logic           can_load;
	logic           full;
	logic           scan_rd;
	logic           wr_en;
	logic           ld;
	logic [7:0]     ld_byte;
	logic           ld_last;
	logic           ld_done;
	logic           ld_well;
	logic [LEN_W-1:0] ld_len;

	assign can_load = !out_valid_q || echo.ready;
	assign full     = (fill_q == CW'(LINE_DEPTH));
	assign scan_rd  = (state_q == ST_SCAN) && (scan_idx_q < fill_q);
	assign cmd_ready = (state_q == ST_IDLE) && can_load;
	assign wr_en    = cmd_valid && cmd_ready && (cmd.op == OP_PUT) && !full;

	assign echo.valid            = out_valid_q;
	assign echo.echo_byte        = echo_byte_q;
	assign echo.last_of_run      = last_q;
	assign echo.line_done        = done_q;
	assign echo.line_well_formed = well_q;
	assign echo.line_length      = len_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[fill_q[AW-1:0]] <= cmd.data;
		end
		if (scan_rd) begin
			rdata_s1 <= store[scan_idx_q[AW-1:0]];
		end
	end

	always_comb begin
		ld      = 1'b0;
		ld_byte = CH_BS;
		ld_last = 1'b0;
		ld_done = 1'b0;
		ld_well = 1'b0;
		ld_len  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && can_load) begin
					case (cmd.op)
						OP_PUT: begin
							ld      = !full;
							ld_byte = cmd.data;
							ld_last = 1'b1;
						end
						OP_DEL: ld = (fill_q != '0);
						default: ld = 1'b0;
					endcase
				end
			end
			ST_DEL_SP: begin
				ld      = can_load;
				ld_byte = CH_SPACE;
			end
			ST_DEL_BS: begin
				ld      = can_load;
				ld_last = 1'b1;
			end
			ST_SCAN: ld = 1'b0;
			ST_CR: begin
				ld      = can_load;
				ld_byte = CH_CR;
			end
			ST_LF: begin
				ld      = can_load;
				ld_byte = CH_LF;
				ld_last = 1'b1;
				ld_done = 1'b1;
				ld_well = !bad_q && (sp2_q || sp3_q);
				ld_len  = LEN_W'(fill_q);
			end
			default: ld = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			scan_idx_q  <= '0;
			bad_q       <= 1'b0;
			sp2_q       <= 1'b0;
			sp3_q       <= 1'b0;
			rd_v_s1     <= 1'b0;
			rd_pos_s1   <= '0;
			out_valid_q <= 1'b0;
			echo_byte_q <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
			well_q      <= 1'b0;
			len_q       <= '0;
		end else begin
			rd_v_s1   <= scan_rd;
			rd_pos_s1 <= scan_idx_q;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						case (cmd.op)
							OP_PUT: begin
								if (!full) begin
									fill_q <= fill_q + CW'(1);
								end
							end
							OP_DEL: begin
								if (fill_q != '0) begin
									fill_q  <= fill_q - CW'(1);
									state_q <= ST_DEL_SP;
								end
							end
							OP_CR: begin
								scan_idx_q <= '0;
								bad_q      <= 1'b0;
								sp2_q      <= 1'b0;
								sp3_q      <= 1'b0;
								state_q    <= ST_SCAN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DEL_SP: if (can_load) state_q <= ST_DEL_BS;
				ST_DEL_BS: if (can_load) state_q <= ST_IDLE;
				ST_SCAN: begin
					if (scan_rd) begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end
					if (rd_v_s1) begin
						if (!hex_or_space(rdata_s1)) begin
							bad_q <= 1'b1;
						end
						if (rd_pos_s1 == CW'(2) && rdata_s1 == CH_SPACE) begin
							sp2_q <= 1'b1;
						end
						if (rd_pos_s1 == CW'(3) && rdata_s1 == CH_SPACE) begin
							sp3_q <= 1'b1;
						end
					end
					if (!scan_rd && !rd_v_s1) begin
						state_q <= ST_CR;
					end
				end
				ST_CR: if (can_load) state_q <= ST_LF;
				ST_LF: begin
					if (can_load) begin
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (ld) begin
				out_valid_q <= 1'b1;
				echo_byte_q <= ld_byte;
				last_q      <= ld_last;
				done_q      <= ld_done;
				well_q      <= ld_well;
				len_q       <= ld_len;
			end else if (echo.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/serial_line_editor_with_echo_core.sv @@
// Top level of the serial line editor: front, command queue and back.
// Depends on sle_pkg, sle_if, sle_front, sle_fifo and sle_back.
//
// Usage:
//   rx   : valid/ready channel of received terminal bytes (rx_byte).
//   echo : valid/ready channel of echo words. Each word carries echo_byte,
//          last_of_run (final word of one input byte), and on the LF word of
//          a carriage return line_done, line_well_formed and line_length.
//   Printable bytes are stored and echoed while the line has room; DEL
//   echoes BS, SP, BS and drops the last character; ESC swallows the next
//   two bytes; CR echoes CR, LF and reports the finished line.
// Timing:
//   The front takes one byte per cycle, while the queue has room, into a
//   four-entry command queue. The back runs one command at a time; DEL
//   echoes its three words from the idle, DEL_SP and DEL_BS states. CR
//   walks the line store one character per cycle through a registered
//   read port before the CR/LF pair leaves. The first echo word of a
//   byte passes through the command queue and the echo register.
// Reset (arst_n low) empties the queue, the line and any pending escape;
//   the store contents are left as they are.
// A stall on echo holds the current word; the back waits, the queue
//   fills, and only then rx.ready drops.
`default_nettype none

module serial_line_editor_with_echo_core #(
	parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sle_rx_if.sink     rx,
	sle_echo_if.source echo
);
	import sle_pkg::*;

	cmd_t fr_cmd;
	logic fr_valid;
	logic fr_ready;
	cmd_t bk_cmd;
	logic bk_valid;
	logic bk_ready;

	// classify and drop escape-skipped bytes
	sle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cmd       (fr_cmd),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready)
	);

	// decouples byte intake from echo back-pressure
	sle_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (fr_cmd),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.pop_cmd    (bk_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready)
	);

	// line store, format scan and echo register
	sle_back #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (bk_cmd),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.echo      (echo)
	);

endmodule

`default_nettype wire

@@ hdl/sle_checker.sv @@
// Port-level checks on the echo channel of the line editor, bound to the top.
// Depends on sle_pkg.
`default_nettype none

module sle_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       echo_valid,
	input  wire logic       echo_ready,
	input  wire logic [7:0] echo_byte,
	input  wire logic       last_of_run,
	input  wire logic       line_done,
	input  wire logic       line_well_formed,
	input  wire logic [5:0] line_length
);
	import sle_pkg::*;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		echo_valid && !echo_ready |=> echo_valid && $stable(echo_byte))
		else $error("echo word changed under stall");

	// line completion only on the closing LF
	a_done_lf: assert property (@(posedge clk) disable iff (!arst_n)
		echo_valid && line_done |-> last_of_run && echo_byte == CH_LF)
		else $error("line_done off the LF word");

	// status fields are zero outside line completion
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		echo_valid && !line_done |-> !line_well_formed && line_length == 6'd0)
		else $error("line status set without line_done");

	// only CR and the DEL sequence produce non-final words
	a_mid_words: assert property (@(posedge clk) disable iff (!arst_n)
		echo_valid && !last_of_run |->
			echo_byte == CH_CR || echo_byte == CH_BS || echo_byte == CH_SPACE)
		else $error("unexpected intermediate echo word");

endmodule

bind serial_line_editor_with_echo_core sle_checker u_sle_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.echo_valid       (echo.valid),
	.echo_ready       (echo.ready),
	.echo_byte        (echo.echo_byte),
	.last_of_run      (echo.last_of_run),
	.line_done        (echo.line_done),
	.line_well_formed (echo.line_well_formed),
	.line_length      (echo.line_length)
);

`default_nettype wire
